[rtl/mdc_pkg.sv]
package mdc_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_PRODUCER_COUNT = 2'd0;
   localparam logic [1:0] REG_SEQ_SPAN = 2'd1;
   localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int FIELD_W = 32;
   localparam int OUTCOME_W = 3;
   localparam int PC_W = 5;
   localparam int MPP_W = 13;
   localparam int LEN_W = 10;

   localparam logic [PC_W-1:0] PC_RESET = 5'd1;
   localparam logic [MPP_W-1:0] MPP_RESET = 13'd1;
   localparam logic [LEN_W-1:0] LEN_RESET = 10'd64;

   localparam logic [FIELD_W-1:0] SHUTDOWN_ID = 32'hFFFF_FFFF;

   // outcome codes
   localparam logic [OUTCOME_W-1:0] OUT_NEW = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_DUP = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_RANGE = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_MALFORMED = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_SHUTDOWN = 3'd4;
   localparam logic [OUTCOME_W-1:0] OUT_IGNORED = 3'd5;

   // bitmap is kept as rows of 32 bits
   localparam int ROW_W = 32;
   localparam int ROW_SEL_W = 5;

   typedef struct packed {
      logic [PC_W-1:0] producer_count;
      logic [MPP_W-1:0] seq_span;
      logic [LEN_W-1:0] expected_length;
   } cfg_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic eval;
      logic read;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic mem_needed;
      logic out_free;
   } status_type;

endpackage

[rtl/mdc_csr.sv]
module mdc_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [mdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mdc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mdc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output mdc_pkg::cfg_type cfg
);
   import mdc_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [MPP_W-1:0] mpp_ff;
   logic [LEN_W-1:0] len_ff;
   logic [1:0] reg_idx;
   logic wr_en;

   assign reg_idx = csr_paddr[3:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_RESET;
         mpp_ff <= MPP_RESET;
         len_ff <= LEN_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_PRODUCER_COUNT: pc_ff <= csr_pwdata[PC_W-1:0];
            REG_SEQ_SPAN: mpp_ff <= csr_pwdata[MPP_W-1:0];
            REG_EXPECTED_LENGTH: len_ff <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PRODUCER_COUNT: csr_prdata = CSR_DATA_W'(pc_ff);
         REG_SEQ_SPAN: csr_prdata = CSR_DATA_W'(mpp_ff);
         REG_EXPECTED_LENGTH: csr_prdata = CSR_DATA_W'(len_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.producer_count = pc_ff;
   assign cfg.seq_span = mpp_ff;
   assign cfg.expected_length = len_ff;

endmodule

[rtl/mdc_ctrl.sv]
module mdc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  mdc_pkg::status_type status,
   output mdc_pkg::cmd_type cmd
);
   import mdc_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_EVAL = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_FIN = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.mem_needed ? ST_READ : ST_FIN;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the result register can take the transaction
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

[rtl/mdc_dpath.sv]
module mdc_dpath #(
   parameter int MAX_PRODUCERS = 16,
   parameter int MAX_SEQUENCE = 4096
) (
   input  logic clock,
   input  logic reset,
   input  mdc_pkg::cfg_type cfg,
   input  mdc_pkg::cmd_type cmd,
   output mdc_pkg::status_type status,
   input  logic [mdc_pkg::FIELD_W-1:0] req_producer_id,
   input  logic [mdc_pkg::FIELD_W-1:0] req_seq_number,
   input  logic [mdc_pkg::FIELD_W-1:0] req_payload_length,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [mdc_pkg::OUTCOME_W-1:0] rsp_outcome,
   output logic [mdc_pkg::FIELD_W-1:0] rsp_received_total,
   output logic [mdc_pkg::FIELD_W-1:0] rsp_duplicate_total,
   output logic [mdc_pkg::FIELD_W-1:0] rsp_range_error_total,
   output logic [mdc_pkg::FIELD_W-1:0] rsp_malformed_total
);
   import mdc_pkg::*;

   localparam int TOTAL = MAX_PRODUCERS * MAX_SEQUENCE;
   localparam int TOT_LOG = $clog2(TOTAL);
   localparam int IDX_W = (TOT_LOG > ROW_SEL_W) ? TOT_LOG : ROW_SEL_W + 1;
   localparam int ROW_AW = IDX_W - ROW_SEL_W;
   localparam int ROWS = 1 << ROW_AW;
   localparam int PID_W = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;
   localparam int PLIM_W = $clog2(MAX_PRODUCERS + 1);
   localparam int SLIM_W = $clog2(MAX_SEQUENCE + 1);
   localparam int PROD_W = PID_W + SLIM_W;
   localparam int SUM_W = PROD_W + 1;

   localparam logic [2:0] CLS_IGNORE = 3'd0;
   localparam logic [2:0] CLS_SHUT = 3'd1;
   localparam logic [2:0] CLS_MALF = 3'd2;
   localparam logic [2:0] CLS_RANGE = 3'd3;
   localparam logic [2:0] CLS_LOOKUP = 3'd4;

   function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] v);
      return (v == '1) ? v : v + FIELD_W'(1);
   endfunction

   logic [FIELD_W-1:0] pid_ff, seq_ff, len_ff;
   logic shut_ff;
   logic [2:0] cls, cls_ff;
   logic [PLIM_W-1:0] plim;
   logic [SLIM_W-1:0] slim;
   logic [PROD_W-1:0] prod_ff;
   logic [IDX_W-1:0] idx;
   logic [ROW_AW-1:0] row_ff;
   logic [ROW_SEL_W-1:0] bit_ff;
   logic [ROW_W-1:0] rd_row_ff;
   logic [ROW_AW-1:0] clr_ptr_ff;
   logic hit;
   logic [ROW_W-1:0] mem [ROWS];

   logic [FIELD_W-1:0] rcv_ff, dup_ff, rng_ff, mal_ff;
   logic [OUTCOME_W-1:0] outcome_ff;
   logic valid_ff;

   // limits clamped to the size of the store
   always_comb begin
      if (32'(cfg.producer_count) < 32'(MAX_PRODUCERS)) begin
         plim = PLIM_W'(cfg.producer_count);
      end else begin
         plim = PLIM_W'(MAX_PRODUCERS);
      end
      if (32'(cfg.seq_span) < 32'(MAX_SEQUENCE)) begin
         slim = SLIM_W'(cfg.seq_span);
      end else begin
         slim = SLIM_W'(MAX_SEQUENCE);
      end
   end

   always_comb begin
      if (shut_ff) begin
         cls = CLS_IGNORE;
      end else if (pid_ff == SHUTDOWN_ID) begin
         cls = CLS_SHUT;
      end else if (len_ff != FIELD_W'(cfg.expected_length)) begin
         cls = CLS_MALF;
      end else if (pid_ff >= FIELD_W'(plim) || seq_ff >= FIELD_W'(slim)) begin
         cls = CLS_RANGE;
      end else begin
         cls = CLS_LOOKUP;
      end
   end

   assign idx = IDX_W'(SUM_W'(prod_ff) + SUM_W'(seq_ff[SLIM_W-1:0]));
   assign hit = rd_row_ff[bit_ff];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pid_ff <= req_producer_id;
         seq_ff <= req_seq_number;
         len_ff <= req_payload_length;
      end
      if (cmd.eval) begin
         cls_ff <= cls;
         prod_ff <= PROD_W'(pid_ff[PID_W-1:0]) * PROD_W'(slim);
      end
      if (cmd.read) begin
         row_ff <= idx[IDX_W-1:ROW_SEL_W];
         bit_ff <= idx[ROW_SEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) rd_row_ff <= mem[idx[IDX_W-1:ROW_SEL_W]];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         mem[clr_ptr_ff] <= '0;
      end else if (cmd.finish && cls_ff == CLS_LOOKUP && !hit) begin
         mem[row_ff] <= rd_row_ff | (ROW_W'(1) << bit_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ptr_ff <= clr_ptr_ff + ROW_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shut_ff <= 1'b0;
         rcv_ff <= '0;
         dup_ff <= '0;
         rng_ff <= '0;
         mal_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            valid_ff <= 1'b1;
            case (cls_ff)
               CLS_IGNORE: outcome_ff <= OUT_IGNORED;
               CLS_SHUT: begin
                  shut_ff <= 1'b1;
                  outcome_ff <= OUT_SHUTDOWN;
               end
               CLS_MALF: begin
                  mal_ff <= sat_inc(mal_ff);
                  outcome_ff <= OUT_MALFORMED;
               end
               CLS_RANGE: begin
                  rcv_ff <= sat_inc(rcv_ff);
                  rng_ff <= sat_inc(rng_ff);
                  outcome_ff <= OUT_RANGE;
               end
               CLS_LOOKUP: begin
                  rcv_ff <= sat_inc(rcv_ff);
                  if (hit) begin
                     dup_ff <= sat_inc(dup_ff);
                     outcome_ff <= OUT_DUP;
                  end else begin
                     outcome_ff <= OUT_NEW;
                  end
               end
               default: outcome_ff <= OUT_IGNORED;
            endcase
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = (clr_ptr_ff == '1);
   assign status.mem_needed = (cls == CLS_LOOKUP);
   assign status.out_free = !valid_ff || rsp_ready;

   // counters only move when a new result is loaded, so they double as payload
   assign rsp_valid = valid_ff;
   assign rsp_outcome = outcome_ff;
   assign rsp_received_total = rcv_ff;
   assign rsp_duplicate_total = dup_ff;
   assign rsp_range_error_total = rng_ff;
   assign rsp_malformed_total = mal_ff;

endmodule

[rtl/message_duplicate_checker.sv]
// flow: a request is captured, classified in the evaluate state and, where the
//   seen-bitmap is looked up, its row is read in the read state; then the result is
//   loaded once the result register is free; one transaction at a time, built around
//   the read-modify-write of a 32-bit bitmap row behind the index multiplier register
// reset: synchronous, active high; then a clearing pass of one bitmap row per cycle
//   over all 2048 rows at the default sizes, during which no request is taken
module message_duplicate_checker #(
   parameter int MAX_PRODUCERS = 16,
   parameter int MAX_SEQUENCE = 4096
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [mdc_pkg::FIELD_W-1:0] req_producer_id,
   input  logic [mdc_pkg::FIELD_W-1:0] req_seq_number,
   input  logic [mdc_pkg::FIELD_W-1:0] req_payload_length,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [mdc_pkg::OUTCOME_W-1:0] rsp_outcome,
   output logic [mdc_pkg::FIELD_W-1:0] rsp_received_total,
   output logic [mdc_pkg::FIELD_W-1:0] rsp_duplicate_total,
   output logic [mdc_pkg::FIELD_W-1:0] rsp_range_error_total,
   output logic [mdc_pkg::FIELD_W-1:0] rsp_malformed_total,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [mdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mdc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mdc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import mdc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   status_type status;

   mdc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   mdc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   mdc_dpath #(
      .MAX_PRODUCERS(MAX_PRODUCERS),
      .MAX_SEQUENCE(MAX_SEQUENCE)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .cmd(cmd),
      .status(status),
      .req_producer_id(req_producer_id),
      .req_seq_number(req_seq_number),
      .req_payload_length(req_payload_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_outcome(rsp_outcome),
      .rsp_received_total(rsp_received_total),
      .rsp_duplicate_total(rsp_duplicate_total),
      .rsp_range_error_total(rsp_range_error_total),
      .rsp_malformed_total(rsp_malformed_total)
   );

endmodule

[rtl/mdc_checker.sv]
module mdc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [mdc_pkg::OUTCOME_W-1:0] rsp_outcome,
   input logic [mdc_pkg::FIELD_W-1:0] rsp_received_total,
   input logic [mdc_pkg::FIELD_W-1:0] rsp_duplicate_total,
   input logic [mdc_pkg::FIELD_W-1:0] rsp_malformed_total
);
   import mdc_pkg::*;

   // bitmap clearing keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request taken or result shown during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome)
         && $stable(rsp_received_total))
      else $error("stalled result changed");

   // every duplicate is also counted as received, and received saturates first
   a_dup_le_rcv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duplicate_total <= rsp_received_total)
      else $error("duplicate total above received total");

   a_dup_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_DUP |-> rsp_duplicate_total != '0)
      else $error("duplicate reported with zero duplicate total");

   a_malf_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OUT_MALFORMED |-> rsp_malformed_total != '0)
      else $error("malformed reported with zero malformed total");

endmodule

bind message_duplicate_checker mdc_checker u_mdc_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_outcome(rsp_outcome),
   .rsp_received_total(rsp_received_total),
   .rsp_duplicate_total(rsp_duplicate_total),
   .rsp_malformed_total(rsp_malformed_total)
);
